>>> rtl/core/mand_pkg.sv
// Shared constants, types and the intensity table for the escape-time pixel block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mand_pkg;

  localparam int ITER_LIMIT = 34;
  localparam int FRAC_BITS  = 28;
  localparam int COORD_W    = 32;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int PIX_W      = 12;
  localparam int SIZE_W     = 13;
  localparam int NUM_W      = PIX_W + FRAC_BITS;
  localparam int CNT_W      = $clog2(ITER_LIMIT + 2);
  localparam int IDX_W      = $clog2(ITER_LIMIT);
  localparam int INTEN_W    = 8;
  localparam int ICNT_W     = 6;
  localparam int INTEN_MAX  = 255;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(600);

  localparam logic [COORD_W-1:0] OFS_X = COORD_W'(3) << (FRAC_BITS - 1);
  localparam logic [COORD_W-1:0] OFS_Y = COORD_W'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_W-1:0]  ESC_LIMIT = PROD_W'(4) << (2 * FRAC_BITS);

  typedef logic [ITER_LIMIT-1:0][INTEN_W-1:0] inten_lut_t;

  function automatic inten_lut_t build_inten_lut();
    inten_lut_t lut;
    for (int i = 0; i < ITER_LIMIT; i++) begin
      lut[i] = INTEN_W'((INTEN_MAX * i) / (ITER_LIMIT - 1));
    end
    return lut;
  endfunction

  localparam inten_lut_t INTEN_LUT = build_inten_lut();

  typedef struct packed {
    logic load;
    logic div_step;
    logic map;
    logic mul;
    logic iter;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic cont;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/core/mand_div.sv
// Restoring divider, one quotient bit per step: (pixel << FRAC_BITS) / size.
// Depends on mand_pkg for widths.
`default_nettype none

module mand_div (
  input  wire logic                       clk_i,
  input  wire logic                       load_i,
  input  wire logic                       step_i,
  input  wire logic [mand_pkg::PIX_W-1:0] pix_i,
  input  wire logic [mand_pkg::SIZE_W-1:0] size_i,
  output logic      [mand_pkg::NUM_W-1:0] quot_o
);
  import mand_pkg::*;

  logic [NUM_W-1:0]  num_q;
  logic [SIZE_W-1:0] rem_q;
  logic [SIZE_W-1:0] dvs_q;
  logic [SIZE_W:0]   trial;
  logic              take;

  assign trial  = {rem_q, num_q[NUM_W-1]};
  assign take   = trial >= {1'b0, dvs_q};
  assign quot_o = num_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_q <= {pix_i, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      dvs_q <= (size_i == '0) ? SIZE_W'(1) : size_i;
    end else if (step_i) begin
      num_q <= {num_q[NUM_W-2:0], take};
      rem_q <= take ? SIZE_W'(trial - {1'b0, dvs_q}) : trial[SIZE_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mand_dp.sv
// Datapath: size registers, coordinate dividers, complex iterate and result registers.
// Depends on mand_pkg and mand_div.
`default_nettype none

module mand_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mand_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [mand_pkg::SIZE_W-1:0]   cfg_data_i,
  input  wire logic [mand_pkg::PIX_W-1:0]    pixel_x_i,
  input  wire logic [mand_pkg::PIX_W-1:0]    pixel_y_i,
  input  wire mand_pkg::cmd_t                cmd_i,
  output mand_pkg::stat_t                    stat_o,
  output logic      [mand_pkg::INTEN_W-1:0]  intensity_o,
  output logic      [mand_pkg::ICNT_W-1:0]   iteration_count_o
);
  import mand_pkg::*;

  localparam int DIFF_W = NUM_W + 2;
  localparam logic signed [DIFF_W-1:0] DIFF_MAX =
    {{(DIFF_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SUM_MAX =
    {{(PROD_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
  localparam logic signed [PROD_W-1:0] SUM_MIN =
    {{(PROD_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};

  logic [SIZE_W-1:0] width_q, height_q;

  logic [NUM_W-1:0] quot_x, quot_y;

  logic signed [COORD_W-1:0] cr_q, ci_q, zr_q, zi_q;
  logic signed [PROD_W-1:0]  sqr_q, sqi_q, prd_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [INTEN_W-1:0]        intensity_q;
  logic [ICNT_W-1:0]         icnt_q;

  logic [PROD_W-1:0]         mag;
  logic signed [PROD_W-1:0]  diff_sq, sum_r, sum_i;

  function automatic logic signed [COORD_W-1:0] map_coord(input logic [NUM_W-1:0] q,
                                                          input logic [COORD_W-1:0] ofs);
    logic signed [DIFF_W-1:0] d;
    d = $signed({2'b00, q}) - $signed({{(DIFF_W - COORD_W){1'b0}}, ofs});
    if (d > DIFF_MAX) begin
      return DIFF_MAX[COORD_W-1:0];
    end
    return d[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] v);
    if (v > SUM_MAX) begin
      return SUM_MAX[COORD_W-1:0];
    end
    if (v < SUM_MIN) begin
      return SUM_MIN[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_RESET;
      height_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mand_div u_div_x (
    .clk_i  (clk_i),
    .load_i (cmd_i.load),
    .step_i (cmd_i.div_step),
    .pix_i  (pixel_x_i),
    .size_i (width_q),
    .quot_o (quot_x)
  );

  mand_div u_div_y (
    .clk_i  (clk_i),
    .load_i (cmd_i.load),
    .step_i (cmd_i.div_step),
    .pix_i  (pixel_y_i),
    .size_i (height_q),
    .quot_o (quot_y)
  );

  assign mag     = sqr_q + sqi_q;
  assign diff_sq = sqr_q - sqi_q;
  assign sum_r   = (diff_sq >>> FRAC_BITS) + PROD_W'(cr_q);
  assign sum_i   = (prd_q >>> (FRAC_BITS - 1)) + PROD_W'(ci_q);

  assign stat_o.cont = (mag < ESC_LIMIT) && (cnt_q <= CNT_W'(ITER_LIMIT));

  always_ff @(posedge clk_i) begin
    if (cmd_i.map) begin
      cr_q  <= map_coord(quot_x, OFS_X);
      ci_q  <= map_coord(quot_y, OFS_Y);
      zr_q  <= '0;
      zi_q  <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.mul) begin
      sqr_q <= PROD_W'(zr_q) * PROD_W'(zr_q);
      sqi_q <= PROD_W'(zi_q) * PROD_W'(zi_q);
      prd_q <= PROD_W'(zr_q) * PROD_W'(zi_q);
    end
    if (cmd_i.iter) begin
      zr_q  <= sat_coord(sum_r);
      zi_q  <= sat_coord(sum_i);
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.finish) begin
      intensity_q <= (cnt_q < CNT_W'(ITER_LIMIT)) ? INTEN_LUT[cnt_q[IDX_W-1:0]] : '0;
      icnt_q      <= ICNT_W'(cnt_q);
    end
  end

  assign intensity_o       = intensity_q;
  assign iteration_count_o = icnt_q;

endmodule

`default_nettype wire

>>> rtl/core/mand_ctrl.sv
// Sequencer: input/output handshakes, divide step count and iteration control.
// Depends on mand_pkg for command and status types.
`default_nettype none

module mand_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire mand_pkg::stat_t stat_i,
  output mand_pkg::cmd_t       cmd_o
);
  import mand_pkg::*;

  localparam int DIVC_W = $clog2(NUM_W);
  localparam logic [DIVC_W-1:0] DIV_LAST = DIVC_W'(NUM_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MAP,
    ST_MUL,
    ST_CHECK,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [DIVC_W-1:0] div_cnt_q;
  logic              out_valid_q;
  logic              out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.map      = (state_q == ST_MAP);
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.iter     = (state_q == ST_CHECK) && stat_i.cont;
    cmd_o.finish   = (state_q == ST_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q   <= ST_DIV;
            div_cnt_q <= '0;
          end
        end
        ST_DIV: begin
          if (div_cnt_q == DIV_LAST) begin
            state_q <= ST_MAP;
          end else begin
            div_cnt_q <= div_cnt_q + DIVC_W'(1);
          end
        end
        ST_MAP:   state_q <= ST_MUL;
        ST_MUL:   state_q <= ST_CHECK;
        ST_CHECK: state_q <= stat_i.cont ? ST_MUL : ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mandelbrot_escape_time_pixel_top.sv
// Top level of the escape-time pixel block: sequencer, datapath and checks.
// Depends on mand_pkg, mand_ctrl, mand_dp (and mand_div below it).
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i/in_ready_o   | pixel_x_i, pixel_y_i
//   out     | out       | out_valid_o/out_ready_i | intensity_o, iteration_count_o
//
// A pixel with n iterations (n = 1 .. 35) goes from acceptance to its result via a
// bit-serial divide, a map of the point, a multiply and a check per escape test
// (n + 1 tests) on the shared multiplier set, then the result register load, held
// while an earlier result waits; then the block returns to idle for the next pixel.
// Reset restores both size registers to 600 and empties the output register.
// A result that waits on out_ready_i holds only the final step; the next pixel is
// accepted while it waits.
`default_nettype none

module mandelbrot_escape_time_pixel_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [mand_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [mand_pkg::SIZE_W-1:0]     cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [mand_pkg::PIX_W-1:0]      pixel_x_i,
  input  wire logic [mand_pkg::PIX_W-1:0]      pixel_y_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [mand_pkg::INTEN_W-1:0]    intensity_o,
  output logic      [mand_pkg::ICNT_W-1:0]     iteration_count_o
);
  import mand_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  mand_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mand_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .pixel_x_i         (pixel_x_i),
    .pixel_y_i         (pixel_y_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .intensity_o       (intensity_o),
    .iteration_count_o (iteration_count_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after a transaction");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> iteration_count_o != '0 &&
                    iteration_count_o <= ICNT_W'(ITER_LIMIT + 1))
    else $error("iteration count out of range");

  a_bounded_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && iteration_count_o >= ICNT_W'(ITER_LIMIT) |-> intensity_o == '0)
    else $error("nonzero intensity for a bounded point");

  a_one_step_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.div_step, cmd.map, cmd.mul, cmd.iter, cmd.finish}))
    else $error("datapath commands overlap");

endmodule

`default_nettype wire
